@@ design/gtc_pkg.sv @@
// Package for the gaze target classifier: payload types, register codes, constants.
`timescale 1ns / 1ps
package gtc_pkg;

    // Coordinate fraction bits (Q4.12 metres by default)
    localparam int COORD_FRAC_BITS_DEF = 12;

    // Request and gaze codes
    localparam logic       REQ_POSE  = 1'b0;
    localparam logic       REQ_LOST  = 1'b1;
    localparam logic [1:0] GAZE_NONE = 2'd0;
    localparam logic [1:0] GAZE_A    = 2'd1;
    localparam logic [1:0] GAZE_B    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_MEAN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_DIAG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_CROSS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MEAN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_DIAG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_B_CROSS = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_THRESH  = 16'd50;
    localparam logic [47:0] RST_A_MEAN  = 48'd24975182593977;
    localparam logic [47:0] RST_A_DIAG  = 48'd3474653708802;
    localparam logic [47:0] RST_A_CROSS = 48'd1769566634257;
    localparam logic [47:0] RST_B_MEAN  = 48'd15556339238886;
    localparam logic [47:0] RST_B_DIAG  = 48'd67435305896712;
    localparam logic [47:0] RST_B_CROSS = 48'd699668102908;

    // Angle units (Q8.7 degrees)
    localparam logic [16:0] DEG360 = 17'd46080;
    localparam logic [16:0] DEG270 = 17'd34560;
    localparam logic [16:0] DEG180 = 17'd23040;
    localparam logic [16:0] DEG90  = 17'd11520;
    localparam logic [13:0] DEG90_14 = 14'd11520;

    // floor(2^28 / 45): r*2^16/11520 == r*256/45
    localparam logic [23:0] RECIP45 = 24'd5965232;
    localparam int          RECIP_SHIFT = 28;

    // Odd series of sin(t*pi/2), Q30
    localparam logic [31:0] C_A1 = 32'd1686629713;
    localparam logic [31:0] C_A3 = 32'd693598668;
    localparam logic [31:0] C_A5 = 32'd85569306;
    localparam logic [31:0] C_A7 = 32'd5026995;
    localparam logic [31:0] C_A9 = 32'd172272;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] head_pos_x;
        logic signed [15:0] head_pos_y;
        logic signed [15:0] head_pos_z;
    } t_gtc_req;

    typedef struct packed {
        logic [1:0]         gaze_target;
        logic signed [15:0] gaze_dir_x;
        logic signed [15:0] gaze_dir_y;
        logic signed [15:0] gaze_dir_z;
    } t_gtc_rsp;

endpackage

@@ design/gaze_target_classifier.sv @@
// Gaze target classifier top level: sequencer around one shared multiplier.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_data  (t_gtc_req)
//  out      | output    | o_out_valid / i_out_stall | o_out_data (t_gtc_rsp)
//  cfg      | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  A pose sample passes through six quarter-wave sines (two per angle, after one angle
//  setup each), 7 direction products, a score for each target and the output step.
//  Every variable product goes through the single 36x24 signed multiplier. A track-lost
//  item goes straight to the output step.
//  o_in_stall is high while an item is in work.
//  The result register frees the input side: a new item is taken while a result
//  waits; a finished item waits for the output register if it is still full.
//  Reset (synchronous, active low) restores the register defaults and clears gaze.
//
module gaze_target_classifier #(
    parameter int COORD_FRAC_BITS = gtc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gtc_pkg::t_gtc_req              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gtc_pkg::t_gtc_rsp              o_out_data,
    input  logic                           i_cfg_we,
    input  logic [gtc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gtc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SCORE_SHIFT = 2 * COORD_FRAC_BITS;
    localparam int RECIP_SHIFT_HI = gtc_pkg::RECIP_SHIFT + 16;

    typedef enum logic [3:0] {
        S_IDLE, S_ANG, S_TMUL, S_TFIX, S_TT, S_HORN, S_PT,
        S_DIR, S_DOT, S_RAYT, S_ERR, S_QUAD, S_CMP, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_thresh;
    logic [47:0] r_a_mean, r_a_diag, r_a_cross, r_b_mean, r_b_diag, r_b_cross;

    // captured item
    logic signed [15:0] r_ang [3];
    logic signed [15:0] r_pos [3];

    // sine evaluation
    logic [1:0]  r_aidx;
    logic        r_half;
    logic [1:0]  r_quad;
    logic [13:0] r_r;
    logic [13:0] r_x;
    logic [16:0] r_t;
    logic [16:0] r_t2;
    logic [31:0] r_p;
    logic [14:0] r_f;
    logic [3:0]  r_cnt;
    logic signed [15:0] r_sn [3];
    logic signed [15:0] r_cs [3];

    // direction and targets
    logic signed [29:0] r_m;
    logic signed [47:0] r_v;
    logic signed [15:0] r_u [3];
    logic               r_tg;
    logic signed [33:0] r_dot;
    logic signed [18:0] r_tt;
    logic signed [18:0] r_e [3];
    logic signed [34:0] r_ce;
    logic signed [59:0] r_q;
    logic [1:0]         r_gaze;

    logic               r_out_valid;
    gtc_pkg::t_gtc_rsp  r_out;

    // shared multiplier
    logic signed [35:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [59:0] mul_p;

    // helpers
    logic signed [15:0] ang_sel;
    logic [16:0]        ang_w;
    logic [13:0]        ang_rem;
    logic [1:0]         ang_quad;
    logic [23:0]        t_rem;
    logic [31:0]        horn_c;
    logic [32:0]        s_raw;
    logic [16:0]        s_rnd;
    logic [14:0]        s_q14;
    logic [47:0]        cur_mean, cur_diag, cur_cross;
    logic signed [16:0] dvec [3];
    logic signed [15:0] cvec [6];
    logic [1:0]         q_i, q_j;
    logic [2:0]         q_c;
    logic               q_cross;
    logic signed [47:0] p48;
    logic signed [47:0] dir_in;
    logic signed [15:0] dir_q;
    logic signed [35:0] ut_rnd;
    logic signed [18:0] e_new;
    logic signed [59:0] q_term;
    logic signed [59:0] score_full;
    logic signed [17:0] score;
    logic               hit;

    function automatic logic signed [15:0] to_q14(input logic signed [47:0] v);
        logic signed [47:0] rs;
        rs = (v + 48'sd134217728) >>> 28;
        if (rs > 48'sd16384) begin
            to_q14 = 16'sd16384;
        end else if (rs < -48'sd16384) begin
            to_q14 = -16'sd16384;
        end else begin
            to_q14 = 16'(rs);
        end
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // angle wrap and quadrant split
    always_comb begin
        ang_sel = r_ang[r_aidx];
        ang_w   = ang_sel[15] ? (17'(ang_sel) + gtc_pkg::DEG360) : 17'(ang_sel);
        if (ang_w >= gtc_pkg::DEG270) begin
            ang_quad = 2'd3;
            ang_rem  = 14'(ang_w - gtc_pkg::DEG270);
        end else if (ang_w >= gtc_pkg::DEG180) begin
            ang_quad = 2'd2;
            ang_rem  = 14'(ang_w - gtc_pkg::DEG180);
        end else if (ang_w >= gtc_pkg::DEG90) begin
            ang_quad = 2'd1;
            ang_rem  = 14'(ang_w - gtc_pkg::DEG90);
        end else begin
            ang_quad = 2'd0;
            ang_rem  = 14'(ang_w);
        end
    end

    // target selection and offsets
    always_comb begin
        cur_mean  = r_tg ? r_b_mean  : r_a_mean;
        cur_diag  = r_tg ? r_b_diag  : r_a_diag;
        cur_cross = r_tg ? r_b_cross : r_a_cross;
        for (int i = 0; i < 3; i++) begin
            dvec[i]     = 17'($signed(cur_mean[16*i +: 16])) - 17'(r_pos[i]);
            cvec[i]     = $signed(cur_diag[16*i +: 16]);
            cvec[3 + i] = $signed(cur_cross[16*i +: 16]);
        end
    end

    // quadratic form term order: xx, yy, zz, xy, xz, yz
    always_comb begin
        q_c = r_cnt[3:1];
        case (r_cnt[3:1])
            3'd0:    begin q_i = 2'd0; q_j = 2'd0; end
            3'd1:    begin q_i = 2'd1; q_j = 2'd1; end
            3'd2:    begin q_i = 2'd2; q_j = 2'd2; end
            3'd3:    begin q_i = 2'd0; q_j = 2'd1; end
            3'd4:    begin q_i = 2'd0; q_j = 2'd2; end
            default: begin q_i = 2'd1; q_j = 2'd2; end
        endcase
        q_cross = (r_cnt[3:1] >= 3'd3);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_TMUL: begin
                mul_a = $signed({14'd0, r_x, 8'd0});
                mul_b = $signed(gtc_pkg::RECIP45);
            end
            S_TT: begin
                mul_a = $signed({19'd0, r_t});
                mul_b = $signed({7'd0, r_t});
            end
            S_HORN: begin
                mul_a = $signed({4'd0, r_p});
                mul_b = $signed({7'd0, r_t2});
            end
            S_PT: begin
                mul_a = $signed({4'd0, r_p});
                mul_b = $signed({7'd0, r_t});
            end
            S_DIR: begin
                case (r_cnt[2:0])
                    3'd0:    begin mul_a = 36'(r_cs[2]); mul_b = 24'(r_sn[1]); end
                    3'd1:    begin mul_a = 36'(r_cs[1]); mul_b = 24'(r_sn[0]); end
                    3'd2:    begin mul_a = 36'(r_m);     mul_b = 24'(r_sn[2]); end
                    3'd3:    begin mul_a = 36'(r_cs[2]); mul_b = 24'(r_cs[1]); end
                    3'd4:    begin mul_a = 36'(r_m);     mul_b = 24'(r_sn[0]); end
                    3'd5:    begin mul_a = 36'(r_sn[2]); mul_b = 24'(r_sn[1]); end
                    default: begin mul_a = 36'(r_cs[0]); mul_b = 24'(r_cs[1]); end
                endcase
            end
            S_DOT: begin
                mul_a = 36'(dvec[r_cnt[1:0]]);
                mul_b = 24'(r_u[r_cnt[1:0]]);
            end
            S_ERR: begin
                mul_a = 36'(r_tt);
                mul_b = 24'(r_u[r_cnt[1:0]]);
            end
            S_QUAD: begin
                if (!r_cnt[0]) begin
                    mul_a = 36'(cvec[q_c]);
                    mul_b = 24'(r_e[q_i]);
                end else begin
                    mul_a = 36'(r_ce);
                    mul_b = 24'(r_e[q_j]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // post-product logic
    always_comb begin
        t_rem = {2'd0, r_x, 8'd0} - (24'(r_t) * 24'd45);
        case (r_cnt[1:0])
            2'd0:    horn_c = gtc_pkg::C_A7;
            2'd1:    horn_c = gtc_pkg::C_A5;
            2'd2:    horn_c = gtc_pkg::C_A3;
            default: horn_c = gtc_pkg::C_A1;
        endcase
        s_raw = {1'b0, mul_p[47:16]} + 33'd32768;
        s_rnd = s_raw[32:16];
        s_q14 = (s_rnd > 17'(gtc_pkg::ONE_Q14)) ? gtc_pkg::ONE_Q14 : s_rnd[14:0];

        p48 = 48'(mul_p);
        case (r_cnt[2:0])
            3'd2:    dir_in = r_v - p48;
            3'd5:    dir_in = r_v - (p48 <<< 14);
            default: dir_in = -(p48 <<< 14);
        endcase
        dir_q = to_q14(dir_in);

        ut_rnd = (36'(mul_p) + 36'sd8192) >>> 14;
        e_new  = 19'(ut_rnd - 36'(dvec[r_cnt[1:0]]));

        q_term = q_cross ? (mul_p <<< 1) : mul_p;

        score_full = r_q >>> SCORE_SHIFT;
        if (score_full < -60'sd65536) begin
            score = -18'sd65536;
        end else if (score_full > 60'sd65535) begin
            score = 18'sd65535;
        end else begin
            score = 18'(score_full);
        end
        hit = (score < $signed({2'd0, r_thresh}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gaze      <= gtc_pkg::GAZE_NONE;
            r_thresh    <= gtc_pkg::RST_THRESH;
            r_a_mean    <= gtc_pkg::RST_A_MEAN;
            r_a_diag    <= gtc_pkg::RST_A_DIAG;
            r_a_cross   <= gtc_pkg::RST_A_CROSS;
            r_b_mean    <= gtc_pkg::RST_B_MEAN;
            r_b_diag    <= gtc_pkg::RST_B_DIAG;
            r_b_cross   <= gtc_pkg::RST_B_CROSS;
            r_cnt       <= '0;
            r_aidx      <= '0;
            r_half      <= 1'b0;
            r_tg        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gtc_pkg::CFG_THRESH:  r_thresh  <= i_cfg_data[15:0];
                    gtc_pkg::CFG_A_MEAN:  r_a_mean  <= i_cfg_data;
                    gtc_pkg::CFG_A_DIAG:  r_a_diag  <= i_cfg_data;
                    gtc_pkg::CFG_A_CROSS: r_a_cross <= i_cfg_data;
                    gtc_pkg::CFG_B_MEAN:  r_b_mean  <= i_cfg_data;
                    gtc_pkg::CFG_B_DIAG:  r_b_diag  <= i_cfg_data;
                    gtc_pkg::CFG_B_CROSS: r_b_cross <= i_cfg_data;
                    default: ;
                endcase
            end

            // output register drains; S_DONE refills it in the same cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ang[0] <= i_in_data.pitch_angle;
                        r_ang[1] <= i_in_data.yaw_angle;
                        r_ang[2] <= i_in_data.roll_angle;
                        r_pos[0] <= i_in_data.head_pos_x;
                        r_pos[1] <= i_in_data.head_pos_y;
                        r_pos[2] <= i_in_data.head_pos_z;
                        r_aidx   <= '0;
                        if (i_in_data.req_type == gtc_pkg::REQ_LOST) begin
                            // track lost: clear gaze, zero direction
                            r_gaze <= gtc_pkg::GAZE_NONE;
                            for (int i = 0; i < 3; i++) begin
                                r_u[i] <= '0;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ANG;
                        end
                    end
                end
                S_ANG: begin
                    r_x     <= ang_rem;
                    r_r     <= ang_rem;
                    r_quad  <= ang_quad;
                    r_half  <= 1'b0;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_t     <= mul_p[RECIP_SHIFT_HI:gtc_pkg::RECIP_SHIFT];
                    r_state <= S_TFIX;
                end
                S_TFIX: begin
                    if (t_rem >= 24'd45) begin
                        r_t <= r_t + 17'd1;
                    end
                    r_state <= S_TT;
                end
                S_TT: begin
                    r_t2    <= mul_p[32:16];
                    r_p     <= gtc_pkg::C_A9;
                    r_cnt   <= '0;
                    r_state <= S_HORN;
                end
                S_HORN: begin
                    r_p <= horn_c - mul_p[47:16];
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= S_PT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_PT: begin
                    if (!r_half) begin
                        // first half done: now the complement for cosine
                        r_f     <= s_q14;
                        r_half  <= 1'b1;
                        r_x     <= gtc_pkg::DEG90_14 - r_r;
                        r_state <= S_TMUL;
                    end else begin
                        case (r_quad)
                            2'd0: begin
                                r_sn[r_aidx] <= 16'(r_f);
                                r_cs[r_aidx] <= 16'(s_q14);
                            end
                            2'd1: begin
                                r_sn[r_aidx] <= 16'(s_q14);
                                r_cs[r_aidx] <= -16'(r_f);
                            end
                            2'd2: begin
                                r_sn[r_aidx] <= -16'(r_f);
                                r_cs[r_aidx] <= -16'(s_q14);
                            end
                            default: begin
                                r_sn[r_aidx] <= -16'(s_q14);
                                r_cs[r_aidx] <= 16'(r_f);
                            end
                        endcase
                        if (r_aidx == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_DIR;
                        end else begin
                            r_aidx  <= r_aidx + 2'd1;
                            r_state <= S_ANG;
                        end
                    end
                end
                S_DIR: begin
                    case (r_cnt[2:0])
                        3'd0:    r_v <= -(p48 <<< 14);
                        3'd1:    r_m <= 30'(mul_p);
                        3'd2:    r_u[0] <= dir_q;
                        3'd3:    r_m <= 30'(mul_p);
                        3'd4:    r_v <= p48;
                        3'd5:    r_u[1] <= dir_q;
                        default: r_u[2] <= dir_q;
                    endcase
                    if (r_cnt[2:0] == 3'd6) begin
                        r_cnt   <= '0;
                        r_tg    <= 1'b0;
                        r_state <= S_DOT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DOT: begin
                    r_dot <= ((r_cnt == 4'd0) ? 34'sd0 : r_dot) + 34'(mul_p);
                    if (r_cnt == 4'd2) begin
                        r_state <= S_RAYT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_RAYT: begin
                    r_tt    <= 19'((r_dot + 34'sd8192) >>> 14);
                    r_cnt   <= '0;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_e[r_cnt[1:0]] <= e_new;
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_state <= S_QUAD;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_QUAD: begin
                    if (!r_cnt[0]) begin
                        r_ce <= 35'(mul_p);
                    end else begin
                        r_q <= ((r_cnt == 4'd1) ? 60'sd0 : r_q) + q_term;
                    end
                    if (r_cnt == 4'd11) begin
                        r_state <= S_CMP;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_CMP: begin
                    if (hit) begin
                        r_gaze <= r_tg ? gtc_pkg::GAZE_B : gtc_pkg::GAZE_A;
                    end
                    r_cnt <= '0;
                    if (!r_tg) begin
                        r_tg    <= 1'b1;
                        r_state <= S_DOT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.gaze_target <= r_gaze;
                        r_out.gaze_dir_x  <= r_u[0];
                        r_out.gaze_dir_y  <= r_u[1];
                        r_out.gaze_dir_z  <= r_u[2];
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/gaze_target_classifier_tb.sv @@
// Self-checking testbench for gaze_target_classifier: random pose traffic and target setups.
`timescale 1ns / 1ps
module gaze_target_classifier_tb;

    // Idle watchdog covers the slowest item and allows a long receiver hold-off on top.
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam int SCORE_SHIFT = 2 * gtc_pkg::COORD_FRAC_BITS_DEF;
    localparam logic [47:0] FULL48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [gtc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    gtc_pkg::t_gtc_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    gtc_pkg::t_gtc_rsp o_out_data;
    logic i_cfg_we = 1'b0;
    logic [gtc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [gtc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    gaze_target_classifier dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: own copy of registers and stored gaze
    logic [15:0] thr_q;
    logic [47:0] tgt_q [6];
    logic [1:0] gaze_q = gtc_pkg::GAZE_NONE;

    gtc_pkg::t_gtc_req pose_queue[$];
    gtc_pkg::t_gtc_rsp expected_rsp[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_rx = 1'b0;
    bit pause_tx = 1'b0;
    bit stim_done = 1'b0;

    function automatic longint fdiv(longint v, int k);
        longint m;
        if (v >= 0) return v >>> k;
        m = -v;
        return -((m + (64'sd1 << k) - 1) >>> k);
    endfunction

    function automatic longint rdiv(longint v, int k);
        return fdiv(v + (64'sd1 << (k - 1)), k);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Quarter-wave polynomial sine, Q1.14 out
    function automatic longint qsine(longint r);
        longint unsigned t, t2, p, s;
        t = (r << 16) / 11520;
        t2 = (t * t) >> 16;
        p = 172272;
        p = 5026995 - ((p * t2) >> 16);
        p = 85569306 - ((p * t2) >> 16);
        p = 693598668 - ((p * t2) >> 16);
        p = 1686629713 - ((p * t2) >> 16);
        s = (p * t) >> 16;
        s = (s + 32768) >> 16;
        return s > 16384 ? 16384 : longint'(s);
    endfunction

    function automatic void sincos(input logic signed [15:0] a, output longint sn,
                                   output longint cs);
        longint w, f, g;
        w = a < 0 ? longint'(a) + 46080 : longint'(a);
        f = qsine(w % 11520);
        g = qsine(11520 - w % 11520);
        case (w / 11520)
            0: begin sn = f; cs = g; end
            1: begin sn = g; cs = -f; end
            2: begin sn = -f; cs = -g; end
            default: begin sn = -g; cs = f; end
        endcase
    endfunction

    function automatic longint field16(logic [47:0] r, int i);
        return longint'($signed(r[16*i +: 16]));
    endfunction

    // Mahalanobis score of the gaze ray against target k, compared with threshold
    function automatic bit target_gate(int k, longint p0[3], longint u[3]);
        longint d[3], e[3], c[6], dotp, t, q;
        for (int i = 0; i < 3; i++) begin
            d[i] = field16(tgt_q[3*k], i) - p0[i];
            c[i] = field16(tgt_q[3*k+1], i);
            c[3+i] = field16(tgt_q[3*k+2], i);
        end
        dotp = d[0]*u[0] + d[1]*u[1] + d[2]*u[2];
        t = rdiv(dotp, 14);
        for (int i = 0; i < 3; i++) e[i] = rdiv(u[i] * t, 14) - d[i];
        q = c[0]*e[0]*e[0] + c[1]*e[1]*e[1] + c[2]*e[2]*e[2]
          + 2 * (c[3]*e[0]*e[1] + c[4]*e[0]*e[2] + c[5]*e[1]*e[2]);
        q = clip(fdiv(q, SCORE_SHIFT), -65536, 65535);
        return q < longint'(thr_q);
    endfunction

    function automatic gtc_pkg::t_gtc_rsp classify_pose(gtc_pkg::t_gtc_req rq);
        gtc_pkg::t_gtc_rsp r;
        longint sp, cp, sy, cy, sr, cr;
        longint u[3], p0[3];
        r = '0;
        if (rq.req_type == gtc_pkg::REQ_LOST) begin
            gaze_q = gtc_pkg::GAZE_NONE;
            return r;
        end
        sincos(rq.pitch_angle, sp, cp);
        sincos(rq.yaw_angle, sy, cy);
        sincos(rq.roll_angle, sr, cr);
        u[0] = clip(rdiv(-(cr*sy)*16384 - cy*sp*sr, 28), -16384, 16384);
        u[1] = clip(rdiv(cr*cy*sp - (sr*sy)*16384, 28), -16384, 16384);
        u[2] = clip(rdiv(-(cp*cy)*16384, 28), -16384, 16384);
        p0[0] = rq.head_pos_x; p0[1] = rq.head_pos_y; p0[2] = rq.head_pos_z;
        if (target_gate(0, p0, u)) gaze_q = gtc_pkg::GAZE_A;
        if (target_gate(1, p0, u)) gaze_q = gtc_pkg::GAZE_B;
        r.gaze_target = gaze_q;
        r.gaze_dir_x = u[0][15:0];
        r.gaze_dir_y = u[1][15:0];
        r.gaze_dir_z = u[2][15:0];
        return r;
    endfunction

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: one transfer per handshake, payload held while stalled
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_rsp.push_back(classify_pose(i_in_data));
                tx_gap = gap_len();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pose_queue.size() > 0 && !pause_tx) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pose_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    errors++;
                end else begin
                    gtc_pkg::t_gtc_rsp x;
                    x = expected_rsp.pop_front();
                    if (x.gaze_target !== o_out_data.gaze_target)
                        $display("%0t: gaze_target exp %0d got %0d", $time,
                                 x.gaze_target, o_out_data.gaze_target);
                    if (x.gaze_dir_x !== o_out_data.gaze_dir_x)
                        $display("%0t: gaze_dir_x exp %0d got %0d", $time,
                                 x.gaze_dir_x, o_out_data.gaze_dir_x);
                    if (x.gaze_dir_y !== o_out_data.gaze_dir_y)
                        $display("%0t: gaze_dir_y exp %0d got %0d", $time,
                                 x.gaze_dir_y, o_out_data.gaze_dir_y);
                    if (x.gaze_dir_z !== o_out_data.gaze_dir_z)
                        $display("%0t: gaze_dir_z exp %0d got %0d", $time,
                                 x.gaze_dir_z, o_out_data.gaze_dir_z);
                    if (x !== o_out_data) errors++;
                end
                rx_gap = gap_len();
            end
            if (hold_rx) i_out_stall <= 1'b1;
            else if (rx_gap > 0) begin
                rx_gap--;
                i_out_stall <= 1'b1;
            end else i_out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (i_rst_n && !hold_rx)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("gaze_target_classifier_tb NOT OK");
            $finish;
        end
    end

    task automatic cfg_write(logic [gtc_pkg::CFG_IDX_W-1:0] idx, logic [47:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == gtc_pkg::CFG_THRESH) thr_q = v[15:0];
        else if (idx <= gtc_pkg::CFG_B_CROSS) tgt_q[idx - 3'd1] = v;
    endtask

    task automatic wait_drained();
        while (pose_queue.size() > 0 || i_in_valid || expected_rsp.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        return $signed(16'($urandom_range(0, 46080))) - 16'sd23040;
    endfunction

    function automatic gtc_pkg::t_gtc_req pose(logic signed [15:0] p, y, r, x, yy, z);
        gtc_pkg::t_gtc_req q;
        q.req_type = gtc_pkg::REQ_POSE;
        q.pitch_angle = p; q.yaw_angle = y; q.roll_angle = r;
        q.head_pos_x = x; q.head_pos_y = yy; q.head_pos_z = z;
        return q;
    endfunction

    // Aim the head at the mean of target k, with small jitter, so hits happen
    function automatic gtc_pkg::t_gtc_req aimed_pose(int k);
        logic [47:0] m;
        logic signed [15:0] jit;
        m = tgt_q[3*k];
        jit = $signed(16'($urandom_range(0, 800))) - 16'sd400;
        return pose(jit, $signed(16'($urandom_range(0, 400))) - 16'sd200,
                    rand_angle(), $signed(m[15:0]) + jit, $signed(m[31:16]),
                    $signed(m[47:32]) + 16'sd4096);
    endfunction

    function automatic gtc_pkg::t_gtc_req random_item(int k);
        gtc_pkg::t_gtc_req q;
        int p = $urandom_range(0, 99);
        if (p < 6) begin
            q = gtc_pkg::t_gtc_req'({$urandom, $urandom, $urandom, $urandom});
            q.req_type = gtc_pkg::REQ_LOST;
        end else if (p < 55) q = aimed_pose(k);
        else if (p < 70) q = aimed_pose(1 - k);
        else begin
            q = pose(rand_angle(), rand_angle(), rand_angle(),
                     16'($urandom), 16'($urandom), 16'($urandom));
        end
        return q;
    endfunction

    initial begin
        thr_q = gtc_pkg::RST_THRESH;
        tgt_q[0] = gtc_pkg::RST_A_MEAN;
        tgt_q[1] = gtc_pkg::RST_A_DIAG;
        tgt_q[2] = gtc_pkg::RST_A_CROSS;
        tgt_q[3] = gtc_pkg::RST_B_MEAN;
        tgt_q[4] = gtc_pkg::RST_B_DIAG;
        tgt_q[5] = gtc_pkg::RST_B_CROSS;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: angle extremes, wrap points, lost events, position extremes
        pose_queue.push_back(pose(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        pose_queue.push_back(pose(16'sd23040, 16'sd23040, 16'sd23040,
                                  16'sd0, 16'sd0, 16'sd0));
        pose_queue.push_back(pose(-16'sd23040, -16'sd23040, -16'sd23040,
                                  16'sd0, 16'sd0, 16'sd0));
        pose_queue.push_back(pose(16'sd11520, -16'sd11520, 16'sd11519,
                                  16'sd0, 16'sd0, 16'sd0));
        pose_queue.push_back(pose(-16'sd1, 16'sd1, -16'sd11521, 16'sh7fff,
                                  16'sh7fff, 16'sh7fff));
        pose_queue.push_back(pose(16'sd0, 16'sd0, 16'sd0,
                                  -16'sd32768, -16'sd32768, -16'sd32768));
        pose_queue.push_back(aimed_pose(0));
        pose_queue.push_back(aimed_pose(1));
        pose_queue.push_back(aimed_pose(0));
        pose_queue.push_back(gtc_pkg::t_gtc_req'({gtc_pkg::REQ_LOST,
                                                  96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF}));
        pose_queue.push_back(aimed_pose(0));
        for (int i = 0; i < 6; i++) pose_queue.push_back(random_item(i % 2));
        wait_drained();

        // Phases: thresholds include zero, max and a negative-form covariance
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: cfg_write(gtc_pkg::CFG_THRESH, 48'hFFFF);
                1: cfg_write(gtc_pkg::CFG_THRESH, 48'd0);
                2: begin
                    cfg_write(gtc_pkg::CFG_A_DIAG, {16'hFF00, 16'h8000, 16'h8000});
                    cfg_write(gtc_pkg::CFG_THRESH, 48'd1000);
                end
                3: cfg_write(gtc_pkg::CFG_B_CROSS, FULL48);
                default: begin
                    cfg_write(gtc_pkg::CFG_THRESH, 48'($urandom_range(0, 3000)));
                    for (int r = 1; r <= 6; r++) begin
                        logic [47:0] v;
                        v = {16'($urandom), 16'($urandom), 16'($urandom)};
                        if (r == 1 || r == 4) v = {16'($urandom_range(0, 8000)),
                            16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000))};
                        if (ph == 6 && r == 2) v = {16'h7fff, 16'h7fff, 16'h7fff};
                        if (ph == 6 && r == 1) v = 48'h0;
                        cfg_write(r[gtc_pkg::CFG_IDX_W-1:0], v);
                    end
                    cfg_write(CFG_UNMAPPED, FULL48);
                end
            endcase
            for (int i = 0; i < 200; i++) pose_queue.push_back(random_item(ph % 2));
            if (ph == 3) begin
                hold_rx = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            if (ph == 5) begin
                while (pose_queue.size() > 100) @(posedge i_clk);
                pause_tx = 1'b1;
                while (i_in_valid || expected_rsp.size() > 0) @(posedge i_clk);
                pause_tx = 1'b0;
            end
            wait_drained();
        end
        if (errors == 0) $display("gaze_target_classifier_tb OK");
        else $display("gaze_target_classifier_tb NOT OK");
        $finish;
    end
endmodule
